[hdl/zsvf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package zsvf_pkg;
   // register indexes
   localparam logic [1:0] CSR_COEF_G = 2'd0;
   localparam logic [1:0] CSR_COEF_DAMPING = 2'd1;
   localparam logic [1:0] CSR_BYPASS = 2'd2;

   // sequencer states
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_ADD  = 5'b00100,
      ST_NEXT = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;
endpackage
`default_nettype wire

[hdl/stereo_zdf_svf_lowpass_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Stereo state-variable low-pass filter (zero-delay feedback, k = 1). One item
// is a left/right pair; the two channels run one after the other through a
// single bit-serial multiplier that retires one coefficient bit per cycle.
// Each channel needs four products; the sequencer then passes ST_NEXT to
// switch channels, and the result is registered in ST_DONE. A bypassed item
// goes from ST_IDLE straight to ST_DONE. A new item is not taken while the
// previous result still waits on rsp_stall. Coefficients g (unsigned Q3.F)
// and d (unsigned Q1.F, clamped to 1.0) are written through the csr port
// while the block is idle; the user must keep to this, as the block itself
// does not enforce it.
module stereo_zdf_svf_lowpass_top #(
   parameter int SAMPLE_BITS = 24,
   parameter int COEF_FRAC_BITS = 16
) (
   input  wire clock,
   input  wire reset,
   input  wire req_valid,
   output logic req_stall,
   input  wire signed [SAMPLE_BITS-1:0] req_left_in,
   input  wire signed [SAMPLE_BITS-1:0] req_right_in,
   input  wire req_clear_state,
   output logic rsp_valid,
   input  wire rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0] rsp_right_out,
   output logic rsp_saturated,
   input  wire csr_write,
   input  wire [1:0] csr_index,
   input  wire [COEF_FRAC_BITS+2:0] csr_data
);
   import zsvf_pkg::*;
   localparam int SB = SAMPLE_BITS + 4;
   localparam int GB = COEF_FRAC_BITS + 3;
   localparam int DB = COEF_FRAC_BITS + 1;
   localparam int KB = GB + 1;          // coefficient operand, holds g + 1
   localparam int MB = SB + 5;          // multiplicand width, holds the unclipped acc
   localparam int PB = MB + KB - COEF_FRAC_BITS + 1;
   localparam logic signed [SB-1:0] S_HI = {1'b0, {(SB-1){1'b1}}};
   localparam logic signed [SB-1:0] S_LO = {1'b1, {(SB-1){1'b0}}};
   localparam logic signed [SAMPLE_BITS-1:0] X_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] X_LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // configuration
   logic [GB-1:0] g_ff;
   logic [DB-1:0] d_ff;
   logic bypass_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         g_ff <= GB'(1) << COEF_FRAC_BITS;
         d_ff <= DB'(21845);
         bypass_ff <= 1'b1;
      end else if (csr_write) begin
         case (csr_index)
            CSR_COEF_G: g_ff <= csr_data[GB-1:0];
            CSR_COEF_DAMPING: d_ff <= csr_data[DB-1:0];
            CSR_BYPASS: bypass_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   logic [DB-1:0] d_eff;
   assign d_eff = (d_ff > (DB'(1) << COEF_FRAC_BITS)) ? (DB'(1) << COEF_FRAC_BITS) : d_ff;

   function automatic logic signed [SB-1:0] sat(input logic signed [PB-1:0] v,
                                               output logic f);
      f = 1'b0;
      if (v > PB'(S_HI)) begin f = 1'b1; sat = S_HI; end
      else if (v < PB'(S_LO)) begin f = 1'b1; sat = S_LO; end
      else sat = v[SB-1:0];
   endfunction

   // state and working registers
   logic signed [SB-1:0] s1_ff [2];
   logic signed [SB-1:0] s2_ff [2];
   logic signed [SAMPLE_BITS-1:0] x_ff [2];
   logic signed [SAMPLE_BITS-1:0] y_ff [2];
   logic signed [PB-1:0] acc_ff;
   logic signed [SB-1:0] hp_ff, v_ff;
   logic ch_ff, flag_ff;
   logic [2:0] step_ff;
   state_type state_ff;
   logic out_valid_ff, out_sat_ff;
   logic signed [SAMPLE_BITS-1:0] out_l_ff, out_r_ff;

   // multiplier operand select
   logic mul_start, mul_done;
   logic signed [MB-1:0] ma;
   logic [KB-1:0] mb;
   logic signed [PB-1:0] mprod;
   always_comb begin
      case (step_ff)
         3'd0: begin
            ma = MB'(s1_ff[ch_ff]);
            mb = KB'(g_ff) + (KB'(1) << COEF_FRAC_BITS);
         end
         3'd1: begin ma = acc_ff[MB-1:0]; mb = KB'(d_eff); end
         3'd2: begin ma = MB'(hp_ff); mb = KB'(g_ff); end
         default: begin ma = MB'(v_ff); mb = KB'(g_ff); end
      endcase
   end
   assign mul_start = (state_ff == ST_MUL);

   zsvf_serial_mul #(.A_BITS(MB), .B_BITS(KB), .FRAC(COEF_FRAC_BITS)) u_mul (
      .clock(clock), .reset(reset), .start(mul_start), .a(ma), .b(mb),
      .done(mul_done), .prod(mprod));

   logic pend;
   assign pend = out_valid_ff && rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || pend;

   // product clip and the two sums after it
   logic f1, f2, f3, f4;
   logic signed [SB-1:0] t1, t2, t3, sum_base;
   logic signed [SAMPLE_BITS-1:0] y_clip;
   always_comb begin
      sum_base = (step_ff == 3'd2) ? s1_ff[ch_ff] : s2_ff[ch_ff];
      t1 = sat(mprod, f1);
      t2 = sat(PB'(t1) + PB'(sum_base), f2);
      t3 = sat(PB'(t1) + PB'(t2), f3);
      f4 = 1'b0;
      if (t2 > SB'(X_HI)) begin
         y_clip = X_HI; f4 = 1'b1;
      end else if (t2 < SB'(X_LO)) begin
         y_clip = X_LO; f4 = 1'b1;
      end else y_clip = t2[SAMPLE_BITS-1:0];
   end

   logic out_load;
   assign out_load = (state_ff == ST_DONE) && !pend;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         s1_ff[0] <= '0; s1_ff[1] <= '0; s2_ff[0] <= '0; s2_ff[1] <= '0;
         ch_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid && !pend) begin
                  x_ff[0] <= req_left_in;
                  x_ff[1] <= req_right_in;
                  flag_ff <= 1'b0;
                  ch_ff <= 1'b0;
                  step_ff <= '0;
                  if (req_clear_state) begin
                     s1_ff[0] <= '0; s1_ff[1] <= '0; s2_ff[0] <= '0; s2_ff[1] <= '0;
                  end
                  if (bypass_ff) begin
                     y_ff[0] <= req_left_in;
                     y_ff[1] <= req_right_in;
                     state_ff <= ST_DONE;
                  end else begin
                     state_ff <= ST_MUL;
                  end
               end
            end
            ST_MUL: state_ff <= ST_ADD;
            ST_ADD: begin
               if (mul_done) begin
                  case (step_ff)
                     3'd0: begin
                        acc_ff <= PB'(x_ff[ch_ff]) - mprod - PB'(s2_ff[ch_ff]);
                        step_ff <= 3'd1;
                        state_ff <= ST_MUL;
                     end
                     3'd1: begin
                        hp_ff <= t1;
                        flag_ff <= flag_ff | f1;
                        step_ff <= 3'd2;
                        state_ff <= ST_MUL;
                     end
                     3'd2: begin
                        v_ff <= t2;
                        s1_ff[ch_ff] <= t3;
                        flag_ff <= flag_ff | f1 | f2 | f3;
                        step_ff <= 3'd3;
                        state_ff <= ST_MUL;
                     end
                     default: begin
                        s2_ff[ch_ff] <= t3;
                        y_ff[ch_ff] <= y_clip;
                        flag_ff <= flag_ff | f1 | f2 | f3 | f4;
                        state_ff <= ST_NEXT;
                     end
                  endcase
               end
            end
            ST_NEXT: begin
               step_ff <= '0;
               if (ch_ff) state_ff <= ST_DONE;
               else begin
                  ch_ff <= 1'b1;
                  state_ff <= ST_MUL;
               end
            end
            ST_DONE: begin
               if (!pend) begin
                  out_l_ff <= y_ff[0];
                  out_r_ff <= y_ff[1];
                  out_sat_ff <= bypass_ff ? 1'b0 : flag_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // result valid
   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (out_load) out_valid_ff <= 1'b1;
      else if (!rsp_stall) out_valid_ff <= 1'b0;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_left_out = out_l_ff;
   assign rsp_right_out = out_r_ff;
   assign rsp_saturated = out_sat_ff;
endmodule
`default_nettype wire

[hdl/zsvf_serial_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
// shift-add multiplier: signed a times unsigned b, one bit of b per cycle,
// result rounded to nearest (ties up) at FRAC bits
module zsvf_serial_mul #(
   parameter int A_BITS = 28,
   parameter int B_BITS = 19,
   parameter int FRAC = 16
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      start,
   input  wire signed [A_BITS-1:0]  a,
   input  wire        [B_BITS-1:0]  b,
   output logic                     done,
   output logic signed [A_BITS+B_BITS-FRAC:0] prod
);
   localparam int P_BITS = A_BITS + B_BITS + 1;
   localparam int CNT_BITS = $clog2(B_BITS + 1);

   logic signed [P_BITS-1:0] acc_ff, acc_in;
   logic signed [P_BITS-1:0] mcand_ff, mcand_in;
   logic [B_BITS-1:0] mplier_ff, mplier_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic signed [P_BITS-1:0] rnd;

   // one partial product per cycle
   always_comb begin
      acc_in = acc_ff;
      mcand_in = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in = P_BITS'(signed'(1) <<< (FRAC - 1));
         mcand_in = P_BITS'(a);
         mplier_in = b;
         cnt_in = CNT_BITS'(B_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff[0]) acc_in = acc_ff + mcand_ff;
         mcand_in = mcand_ff <<< 1;
         mplier_in = mplier_ff >> 1;
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      acc_ff <= acc_in;
      mcand_ff <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign rnd = acc_ff >>> FRAC;
   assign done = done_ff;
   assign prod = rnd[A_BITS+B_BITS-FRAC:0];
endmodule
`default_nettype wire

[hdl/zsvf_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module zsvf_checker (
   input wire clock,
   input wire reset,
   input wire req_valid,
   input wire req_stall,
   input wire rsp_valid,
   input wire rsp_stall,
   input wire rsp_saturated
);
   // a stalled result stays offered
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("result dropped");
   // an accepted item blocks the next one
   a_one: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall) else $error("second item taken");
   // no result right out of reset
   a_rst: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("valid after reset");
   // flag stable while stalled
   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_saturated)) else $error("flag moved");
endmodule
bind stereo_zdf_svf_lowpass_top zsvf_checker u_chk (.*);
`default_nettype wire

[verif/stereo_zdf_svf_lowpass_top_tb.sv]
`timescale 1ns / 1ps
module stereo_zdf_svf_lowpass_top_tb;
   import zsvf_pkg::*;

   localparam int SB = 24;
   localparam int CF = 16;
   localparam int ST = SB + 4;
   localparam int N_RANDOM = 1150;
   localparam int PHASES = 6;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [SB-1:0] req_left_in = '0;
   logic signed [SB-1:0] req_right_in = '0;
   logic req_clear_state = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [SB-1:0] rsp_left_out;
   logic signed [SB-1:0] rsp_right_out;
   logic rsp_saturated;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = CSR_COEF_G;
   logic [CF+2:0] csr_data = '0;

   typedef struct packed {
      logic signed [SB-1:0] left;
      logic signed [SB-1:0] right;
      logic clear;
   } pair_type;

   typedef struct packed {
      logic signed [SB-1:0] left;
      logic signed [SB-1:0] right;
      logic sat;
   } lowpass_type;

   pair_type pending_pairs[$];
   lowpass_type expected_outputs[$];
   int errors = 0;
   bit quiet_stretch = 1'b0;
   bit hold_sender = 1'b0;

   // filter model state and coefficients
   longint mdl_g, mdl_d;
   bit mdl_bypass;
   longint s1_l, s2_l, s1_r, s2_r;

   stereo_zdf_svf_lowpass_top DUT (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic longint rnd_shift(longint v);
      longint t;
      t = v + (longint'(1) << (CF - 1));
      return t >>> CF;
   endfunction

   function automatic longint sat_to(longint v, int bits, inout bit flag);
      longint hi, lo;
      hi = (longint'(1) << (bits - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         flag = 1'b1;
         return hi;
      end
      if (v < lo) begin
         flag = 1'b1;
         return lo;
      end
      return v;
   endfunction

   function automatic longint svf_channel(longint x, inout longint s1, inout longint s2,
                                          inout bit flag);
      longint d, acc, hp, v1, v, v2, lp;
      d = (mdl_d > (longint'(1) << CF)) ? (longint'(1) << CF) : mdl_d;
      acc = x - rnd_shift((mdl_g + (longint'(1) << CF)) * s1) - s2;
      hp = sat_to(rnd_shift(acc * d), ST, flag);
      v1 = sat_to(rnd_shift(mdl_g * hp), ST, flag);
      v = sat_to(v1 + s1, ST, flag);
      s1 = sat_to(v1 + v, ST, flag);
      v2 = sat_to(rnd_shift(mdl_g * v), ST, flag);
      lp = sat_to(v2 + s2, ST, flag);
      s2 = sat_to(v2 + lp, ST, flag);
      return sat_to(lp, SB, flag);
   endfunction

   function automatic lowpass_type filter_pair(pair_type p);
      lowpass_type r;
      bit flag;
      flag = 1'b0;
      if (p.clear) begin
         s1_l = 0;
         s2_l = 0;
         s1_r = 0;
         s2_r = 0;
      end
      if (mdl_bypass) begin
         r.left = p.left;
         r.right = p.right;
      end else begin
         r.left = SB'(svf_channel(longint'(p.left), s1_l, s2_l, flag));
         r.right = SB'(svf_channel(longint'(p.right), s1_r, s2_r, flag));
      end
      r.sat = flag;
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (pending_pairs.size() > 0 && !hold_sender &&
             (quiet_stretch || $urandom_range(99) >= 11)) begin
            pair_type p;
            p = pending_pairs.pop_front();
            req_valid <= 1'b1;
            req_left_in <= p.left;
            req_right_in <= p.right;
            req_clear_state <= p.clear;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // predict on acceptance
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         expected_outputs.push_back(filter_pair({req_left_in, req_right_in, req_clear_state}));
   end

   // monitor and receiver stall
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_outputs.size() == 0) begin
            $display("%0t: unexpected item %h %h %b", $time, rsp_left_out, rsp_right_out,
                     rsp_saturated);
            errors++;
         end else begin
            lowpass_type e;
            e = expected_outputs.pop_front();
            if (rsp_left_out !== e.left) begin
               $display("%0t: left_out expected %h actual %h", $time, e.left, rsp_left_out);
               errors++;
            end
            if (rsp_right_out !== e.right) begin
               $display("%0t: right_out expected %h actual %h", $time, e.right, rsp_right_out);
               errors++;
            end
            if (rsp_saturated !== e.sat) begin
               $display("%0t: saturated expected %b actual %b", $time, e.sat, rsp_saturated);
               errors++;
            end
         end
      end
      rsp_stall <= reset ? 1'b0 : (!quiet_stretch && $urandom_range(99) < 11);
   end

   task automatic write_csr(logic [1:0] idx, int unsigned value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value[CF+2:0];
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_COEF_G) mdl_g = value & ((1 << (CF + 3)) - 1);
      else if (idx == CSR_COEF_DAMPING) mdl_d = value & ((1 << (CF + 1)) - 1);
      else mdl_bypass = value[0];
   endtask

   task automatic wait_drained();
      while (pending_pairs.size() > 0 || req_valid || expected_outputs.size() > 0)
         @(negedge clock);
      repeat (300) @(posedge clock);
   endtask

   function automatic logic signed [SB-1:0] rand_sample(int span);
      case ($urandom_range(5))
         0: return {1'b0, {(SB-1){1'b1}}};
         1: return {1'b1, {(SB-1){1'b0}}};
         2: return SB'($urandom);
         default: return SB'(int'($urandom_range(2 * span)) - span);
      endcase
   endfunction

   task automatic queue_pair(logic signed [SB-1:0] l, logic signed [SB-1:0] r, logic c);
      pair_type p;
      p.left = l;
      p.right = r;
      p.clear = c;
      pending_pairs.push_back(p);
   endtask

   initial begin
      int g_set[PHASES] = '{65536, 0, 524287, 6554, 200000, 30000};
      int d_set[PHASES] = '{21845, 65536, 65535, 60000, 0, 90000 % 131072};
      mdl_g = 65536;
      mdl_d = 21845;
      mdl_bypass = 1'b1;
      s1_l = 0;
      s2_l = 0;
      s1_r = 0;
      s2_r = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // bypass after reset, extremes and clear during bypass
      queue_pair({1'b0, {(SB-1){1'b1}}}, {1'b1, {(SB-1){1'b0}}}, 1'b0);
      queue_pair('0, -1, 1'b1);
      queue_pair(24'sh123456, -24'sh654321, 1'b0);
      wait_drained();

      // filtering: step, extremes, saturation, clear
      write_csr(CSR_BYPASS, 0);
      repeat (6) queue_pair({1'b0, {(SB-1){1'b1}}}, {1'b1, {(SB-1){1'b0}}}, 1'b0);
      queue_pair('0, '0, 1'b1);
      repeat (4) queue_pair(24'sh100000, -24'sh100000, 1'b0);
      wait_drained();
      write_csr(CSR_COEF_DAMPING, 131071);
      write_csr(CSR_COEF_G, 524287);
      repeat (8) queue_pair({1'b0, {(SB-1){1'b1}}}, {1'b1, {(SB-1){1'b0}}}, 1'b0);
      queue_pair(-1, 1, 1'b1);
      wait_drained();

      // random phases through coefficient settings
      for (int ph = 0; ph < PHASES; ph++) begin
         write_csr(CSR_COEF_G, g_set[ph]);
         write_csr(CSR_COEF_DAMPING, d_set[ph]);
         write_csr(CSR_BYPASS, (ph == 3) ? 1 : 0);
         quiet_stretch = (ph == 2);
         for (int i = 0; i < N_RANDOM / PHASES; i++) begin
            int span;
            span = ($urandom_range(3) == 0) ? 8388607 : 1 << $urandom_range(4, 22);
            queue_pair(rand_sample(span), rand_sample(span), $urandom_range(49) == 0);
         end
         if (ph == 1) begin
            // hold off until every result has come
            while (pending_pairs.size() > 100) @(posedge clock);
            hold_sender = 1'b1;
            @(posedge clock);
            while (req_valid || expected_outputs.size() > 0) @(negedge clock);
            hold_sender = 1'b0;
         end
         wait_drained();
      end

      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #5000000;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule
